// ----- src/telnet_receive_negotiator_core_macros.svh -----
// Assertion macros shared by the telnet receive negotiator.
`ifndef TELNET_RECEIVE_NEGOTIATOR_CORE_MACROS_SVH
`define TELNET_RECEIVE_NEGOTIATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled in reset.
`define TNRN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("telnet negotiator check failed");

// Next-cycle implication, sampled on clk_i and disabled in reset.
`define TNRN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("telnet negotiator check failed");

`endif

// ----- src/tnrn_pkg.sv -----
// Shared types, codes and tables of the telnet receive negotiator.
`default_nettype none
package tnrn_pkg;

  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_SE   = 8'd240;

  localparam logic [7:0] OPT_BIN  = 8'd0;
  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_NUL = 8'd0;

  localparam logic [1:0] V_WILL = 2'd0;
  localparam logic [1:0] V_WONT = 2'd1;
  localparam logic [1:0] V_DO   = 2'd2;
  localparam logic [1:0] V_DONT = 2'd3;

  localparam logic [1:0] OS_OFF     = 2'd0;
  localparam logic [1:0] OS_ON      = 2'd1;
  localparam logic [1:0] OS_REFUSED = 2'd2;

  typedef enum logic [1:0] {
    K_DATA,
    K_OPT,
    K_GREET
  } kind_e;

  typedef enum logic [1:0] {
    M_DATA,
    M_CMD,
    M_GREET
  } mode_e;

  typedef struct packed {
    logic       enq;
    kind_e      kind;
    logic [7:0] dat;
    logic [1:0] verb;
  } req_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] verb_code;
    logic [7:0] dat;
  } desc_t;

  function automatic logic [7:0] greet_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0, 4'd3, 4'd6, 4'd9: b = TN_IAC;
      4'd1, 4'd4, 4'd7:       b = TN_WILL;
      4'd10:                  b = TN_DO;
      4'd2:                   b = OPT_ECHO;
      4'd5:                   b = OPT_SGA;
      default:                b = OPT_BIN;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- src/tnrn_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tnrn_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- src/tnrn_parser.sv -----
// IAC parser: tracks command state and carriage returns, and classifies each word.
`default_nettype none
module tnrn_parser import tnrn_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic       func_i,
  input  wire logic [7:0] rx_byte_i,
  output      req_t       req_o
);

  typedef enum logic [2:0] {
    PS_DATA,
    PS_IAC,
    PS_OPT,
    PS_SB,
    PS_SB_IAC
  } pstate_e;

  pstate_e    state_q, state_d;
  logic [1:0] verb_q, verb_d;
  logic       cr_q, cr_d;

  always_comb begin
    state_d    = state_q;
    verb_d     = verb_q;
    cr_d       = cr_q;
    req_o.enq  = 1'b0;
    req_o.kind = K_DATA;
    req_o.dat  = rx_byte_i;
    req_o.verb = verb_q;
    if (func_i) begin
      req_o.enq  = 1'b1;
      req_o.kind = K_GREET;
    end else begin
      case (state_q)
        PS_DATA: begin
          if (rx_byte_i == TN_IAC) begin
            state_d = PS_IAC;
          end else begin
            cr_d      = (rx_byte_i == CH_CR);
            req_o.enq = !(cr_q && ((rx_byte_i == CH_LF) || (rx_byte_i == CH_NUL)));
          end
        end
        PS_IAC: begin
          state_d = PS_DATA;
          if (rx_byte_i == TN_IAC) begin
            req_o.enq = 1'b1;
          end else if ((rx_byte_i >= TN_WILL) && (rx_byte_i <= TN_DONT)) begin
            verb_d  = 2'(rx_byte_i - TN_WILL);
            state_d = PS_OPT;
          end else if (rx_byte_i == TN_SB) begin
            state_d = PS_SB;
          end
        end
        PS_OPT: begin
          req_o.enq  = 1'b1;
          req_o.kind = K_OPT;
          state_d    = PS_DATA;
        end
        PS_SB: begin
          if (rx_byte_i == TN_IAC) begin
            state_d = PS_SB_IAC;
          end
        end
        PS_SB_IAC: begin
          state_d = (rx_byte_i == TN_SE) ? PS_DATA : PS_SB;
        end
        default: begin
          state_d = PS_DATA;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_DATA;
      verb_q  <= V_WILL;
      cr_q    <= 1'b0;
    end else if (acc_i) begin
      state_q <= state_d;
      verb_q  <= verb_d;
      cr_q    <= cr_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/tnrn_emit.sv -----
// Output sequencer: holds one run of result words and hands them out one at a time.
`default_nettype none
module tnrn_emit import tnrn_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire desc_t      desc_i,
  output      logic       free_o,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic       channel_o,
  output      logic [7:0] data_byte_o,
  output      logic       last_of_run_o
);

  logic       busy_q;
  desc_t      desc_q;
  logic [3:0] idx_q;
  logic [3:0] last_idx;

  always_comb begin
    case (desc_q.mode)
      M_DATA:  last_idx = 4'd0;
      M_CMD:   last_idx = 4'd2;
      M_GREET: last_idx = 4'd11;
      default: last_idx = 4'd0;
    endcase
  end

  always_comb begin
    channel_o = 1'b1;
    case (desc_q.mode)
      M_DATA: begin
        channel_o   = 1'b0;
        data_byte_o = desc_q.dat;
      end
      M_CMD: begin
        case (idx_q)
          4'd0:    data_byte_o = TN_IAC;
          4'd1:    data_byte_o = desc_q.verb_code;
          default: data_byte_o = desc_q.dat;
        endcase
      end
      default: begin
        data_byte_o = greet_byte(idx_q);
      end
    endcase
  end

  assign out_valid_o   = busy_q;
  assign last_of_run_o = (idx_q == last_idx);
  assign free_o        = !busy_q || (out_ready_i && last_of_run_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 4'd0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= 4'd0;
    end else if (busy_q && out_ready_i) begin
      if (last_of_run_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
    end
  end

endmodule
`default_nettype wire

// ----- src/telnet_receive_negotiator_core.sv -----
// Top level of the telnet receive negotiator: parser, option tables and output sequencer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | to core   | in_valid_i / in_ready_o | func_i, rx_byte_i
//   out     | from core | out_valid_o/out_ready_i | channel_o, data_byte_o, last_of_run_o
//
// A data word or command word is taken every cycle while the output drains at one word a cycle.
// An option word reads both option memories on acceptance and writes back when it leaves the holding stage.
// A three-word reply holds the input back while it drains; the greeting holds it during its table
// writes for ECHO, SGA and BIN and then while its twelve words drain.
// After reset a sweep writes all 256 entries of both option tables to off, with
// in_ready_o held low.
// Stalls on the output side back up through the single holding stage to in_ready_o.
`default_nettype none
module telnet_receive_negotiator_core import tnrn_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic       func_i,
  input  wire logic [7:0] rx_byte_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic       channel_o,
  output      logic [7:0] data_byte_o,
  output      logic       last_of_run_o
);

  req_t       req;
  logic       acc;
  logic       rd_en;

  logic       s1_valid_q;
  kind_e      s1_kind_q;
  logic [7:0] s1_dat_q;
  logic [1:0] s1_verb_q;
  logic [1:0] g_cnt_q;
  logic       s1_move;

  logic       clr_q;
  logic [7:0] clr_addr_q;

  logic       l_we, r_we;
  logic [7:0] l_waddr, r_waddr;
  logic [1:0] l_wdata, r_wdata;
  logic [1:0] l_rdata, r_rdata;
  logic       l_fwd_q, r_fwd_q;
  logic [1:0] l_fwd_data_q, r_fwd_data_q;
  logic [1:0] my_st, his_st;

  logic       change;
  logic       to_local;
  logic [1:0] new_st;
  logic [7:0] reply;

  logic       emit_free;
  logic       emit_load;
  desc_t      emit_desc;

  tnrn_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .func_i    (func_i),
    .rx_byte_i (rx_byte_i),
    .req_o     (req)
  );

  assign in_ready_o = !clr_q && (!s1_valid_q || s1_move);
  assign acc        = in_valid_i && in_ready_o;
  assign rd_en      = acc && req.enq && (req.kind == K_OPT);

  assign my_st  = l_fwd_q ? l_fwd_data_q : l_rdata;
  assign his_st = r_fwd_q ? r_fwd_data_q : r_rdata;

  always_comb begin
    change   = 1'b0;
    to_local = 1'b1;
    new_st   = OS_OFF;
    reply    = TN_WONT;
    case (s1_verb_q)
      V_DO: begin
        if ((s1_dat_q == OPT_ECHO) || (s1_dat_q == OPT_SGA) || (s1_dat_q == OPT_BIN)) begin
          change = (my_st != OS_ON);
          new_st = OS_ON;
          reply  = TN_WILL;
        end else begin
          change = (my_st != OS_REFUSED);
          new_st = OS_REFUSED;
        end
      end
      V_DONT: begin
        change = (my_st == OS_ON);
      end
      V_WILL: begin
        to_local = 1'b0;
        if (s1_dat_q == OPT_BIN) begin
          change = (his_st == OS_OFF);
          new_st = OS_ON;
          reply  = TN_DO;
        end else begin
          change = (his_st != OS_REFUSED);
          new_st = OS_REFUSED;
          reply  = TN_DONT;
        end
      end
      default: begin
        to_local = 1'b0;
        change   = (his_st == OS_ON);
        reply    = TN_DONT;
      end
    endcase
  end

  always_comb begin
    case (s1_kind_q)
      K_DATA:  s1_move = s1_valid_q && emit_free;
      K_OPT:   s1_move = s1_valid_q && (!change || emit_free);
      K_GREET: s1_move = s1_valid_q && (g_cnt_q == 2'd2) && emit_free;
      default: s1_move = s1_valid_q;
    endcase
  end

  always_comb begin
    case (g_cnt_q)
      2'd0:    l_waddr = OPT_ECHO;
      2'd1:    l_waddr = OPT_SGA;
      default: l_waddr = OPT_BIN;
    endcase
    l_wdata = OS_ON;
    l_we    = s1_valid_q && (s1_kind_q == K_GREET);
    if (s1_kind_q == K_OPT) begin
      l_waddr = s1_dat_q;
      l_wdata = new_st;
      l_we    = s1_move && change && to_local;
    end
    if (clr_q) begin
      l_waddr = clr_addr_q;
      l_wdata = OS_OFF;
      l_we    = 1'b1;
    end
  end

  assign r_we    = clr_q || (s1_move && (s1_kind_q == K_OPT) && change && !to_local);
  assign r_waddr = clr_q ? clr_addr_q : s1_dat_q;
  assign r_wdata = clr_q ? OS_OFF : new_st;

  tnrn_ram #(.WIDTH(2), .DEPTH(256)) u_local_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (rd_en),
    .raddr_i (rx_byte_i),
    .rdata_o (l_rdata)
  );

  tnrn_ram #(.WIDTH(2), .DEPTH(256)) u_remote_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .re_i    (rd_en),
    .raddr_i (rx_byte_i),
    .rdata_o (r_rdata)
  );

  always_comb begin
    emit_desc.verb_code = reply;
    emit_desc.dat       = s1_dat_q;
    case (s1_kind_q)
      K_DATA:  emit_desc.mode = M_DATA;
      K_OPT:   emit_desc.mode = M_CMD;
      default: emit_desc.mode = M_GREET;
    endcase
  end

  assign emit_load = s1_move && ((s1_kind_q != K_OPT) || change);

  tnrn_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (emit_load),
    .desc_i        (emit_desc),
    .free_o        (emit_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .channel_o     (channel_o),
    .data_byte_o   (data_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_kind_q  <= K_DATA;
      g_cnt_q    <= 2'd0;
      clr_q      <= 1'b1;
      clr_addr_q <= 8'd0;
      l_fwd_q    <= 1'b0;
      r_fwd_q    <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 8'd1;
        if (clr_addr_q == 8'd255) begin
          clr_q <= 1'b0;
        end
      end
      if (acc && req.enq) begin
        s1_valid_q <= 1'b1;
        s1_kind_q  <= req.kind;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        g_cnt_q <= 2'd0;
      end else if (s1_valid_q && (s1_kind_q == K_GREET) && (g_cnt_q != 2'd2)) begin
        g_cnt_q <= g_cnt_q + 2'd1;
      end
      if (rd_en) begin
        l_fwd_q <= l_we && (l_waddr == rx_byte_i);
        r_fwd_q <= r_we && (r_waddr == rx_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && req.enq) begin
      s1_dat_q  <= req.dat;
      s1_verb_q <= req.verb;
    end
    if (rd_en) begin
      l_fwd_data_q <= l_wdata;
      r_fwd_data_q <= r_wdata;
    end
  end

`include "telnet_receive_negotiator_core_macros.svh"

  `TNRN_ASSERT_NOW(a_read_not_over_held_option, rd_en, !(s1_valid_q && (s1_kind_q == K_OPT) && !s1_move))
  `TNRN_ASSERT_NEXT(a_read_fills_option_stage, rd_en, s1_valid_q && (s1_kind_q == K_OPT))
  `TNRN_ASSERT_NOW(a_greet_leaves_after_writes, s1_move && (s1_kind_q == K_GREET), l_we && (l_waddr == OPT_BIN))
  `TNRN_ASSERT_NEXT(a_run_end_drains, out_valid_o && out_ready_i && last_of_run_o && !emit_load, !out_valid_o)

endmodule
`default_nettype wire

// ----- tb/telnet_receive_negotiator_core_test.sv -----
// Self-checking testbench for the telnet receive negotiator, with a directed table and random phrases.
`timescale 1ns / 1ps
module telnet_receive_negotiator_core_test;
  import tnrn_pkg::*;

  localparam logic       FN_RX     = 1'b0;
  localparam logic       FN_GREET  = 1'b1;
  localparam logic       CHAN_USER = 1'b0;
  localparam logic       CHAN_PEER = 1'b1;
  localparam logic [7:0] TN_NOP    = 8'd241;
  localparam logic [8:0] NO_WORD   = 9'd0;

  typedef enum logic [2:0] {
    PS_DATA,
    PS_IAC,
    PS_OPT,
    PS_SB,
    PS_SB_IAC
  } parse_e;

  typedef struct packed {
    logic       chan;
    logic [7:0] dbyte;
    logic       last;
  } word_t;

  typedef struct packed {
    logic            func;
    logic [7:0]      rx;
    logic            typed;
    logic [1:0]      n;
    logic [2:0][8:0] res;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       func_i;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       channel_o;
  logic [7:0] data_byte_o;
  logic       last_of_run_o;

  parse_e     parse_q;
  logic [1:0] verb_q;
  logic       cr_q;
  logic [1:0] local_opts [256];
  logic [1:0] remote_opts [256];

  word_t      reply_q [$];
  row_t       table_rows [$];
  row_t       word_row;
  int         error_count = 0;
  int         sent = 0;
  bit         idle_in = 1'b1;
  bit         idle_out = 1'b1;

  telnet_receive_negotiator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .channel_o     (channel_o),
    .data_byte_o   (data_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic note_error(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic void emit(input logic chan, input logic [7:0] b);
    word_t w;
    w.chan  = chan;
    w.dbyte = b;
    w.last  = 1'b0;
    reply_q.push_back(w);
  endfunction

  function automatic void queue_reply(input logic [7:0] verb, input logic [7:0] opt);
    emit(CHAN_PEER, TN_IAC);
    emit(CHAN_PEER, verb);
    emit(CHAN_PEER, opt);
  endfunction

  function automatic void negotiate(input logic [1:0] verb, input logic [7:0] opt);
    case (verb)
      V_DO: begin
        if (opt == OPT_ECHO || opt == OPT_SGA || opt == OPT_BIN) begin
          if (local_opts[opt] != OS_ON) begin
            local_opts[opt] = OS_ON;
            queue_reply(TN_WILL, opt);
          end
        end else if (local_opts[opt] != OS_REFUSED) begin
          local_opts[opt] = OS_REFUSED;
          queue_reply(TN_WONT, opt);
        end
      end
      V_DONT: begin
        if (local_opts[opt] == OS_ON) begin
          local_opts[opt] = OS_OFF;
          queue_reply(TN_WONT, opt);
        end
      end
      V_WILL: begin
        if (opt == OPT_BIN) begin
          if (remote_opts[opt] == OS_OFF) begin
            remote_opts[opt] = OS_ON;
            queue_reply(TN_DO, opt);
          end
        end else if (remote_opts[opt] != OS_REFUSED) begin
          remote_opts[opt] = OS_REFUSED;
          queue_reply(TN_DONT, opt);
        end
      end
      default: begin
        if (remote_opts[opt] == OS_ON) begin
          remote_opts[opt] = OS_OFF;
          queue_reply(TN_DONT, opt);
        end
      end
    endcase
  endfunction

  // Works out the words that one accepted input word causes and queues them.
  function automatic void telnet_step(input logic f, input logic [7:0] c);
    int    mark;
    bit    drop;
    word_t w;
    mark = reply_q.size();
    if (f == FN_GREET) begin
      local_opts[OPT_ECHO] = OS_ON;
      queue_reply(TN_WILL, OPT_ECHO);
      local_opts[OPT_SGA] = OS_ON;
      queue_reply(TN_WILL, OPT_SGA);
      local_opts[OPT_BIN] = OS_ON;
      queue_reply(TN_WILL, OPT_BIN);
      queue_reply(TN_DO, OPT_BIN);
    end else begin
      case (parse_q)
        PS_DATA: begin
          if (c == TN_IAC) begin
            parse_q = PS_IAC;
          end else begin
            drop = 1'b0;
            if (cr_q) begin
              cr_q = 1'b0;
              drop = (c == CH_LF || c == CH_NUL);
            end
            if (!drop) begin
              if (c == CH_CR) cr_q = 1'b1;
              emit(CHAN_USER, c);
            end
          end
        end
        PS_IAC: begin
          if (c == TN_IAC) begin
            emit(CHAN_USER, TN_IAC);
            parse_q = PS_DATA;
          end else if (c >= TN_WILL && c <= TN_DONT) begin
            verb_q  = 2'(c - TN_WILL);
            parse_q = PS_OPT;
          end else if (c == TN_SB) begin
            parse_q = PS_SB;
          end else begin
            parse_q = PS_DATA;
          end
        end
        PS_OPT: begin
          negotiate(verb_q, c);
          parse_q = PS_DATA;
        end
        PS_SB: begin
          if (c == TN_IAC) parse_q = PS_SB_IAC;
        end
        PS_SB_IAC: begin
          parse_q = (c == TN_SE) ? PS_DATA : PS_SB;
        end
        default: begin
          parse_q = PS_DATA;
        end
      endcase
    end
    if (reply_q.size() > mark) begin
      w = reply_q.pop_back();
      w.last = 1'b1;
      reply_q.push_back(w);
    end
  endfunction

  function automatic row_t mk(input logic f, input logic [7:0] b);
    row_t r;
    r       = '0;
    r.func  = f;
    r.rx    = b;
    return r;
  endfunction

  task automatic add_row(input logic f, input logic [7:0] b, input logic typed,
                         input logic [1:0] n, input logic [8:0] a0, input logic [8:0] a1,
                         input logic [8:0] a2);
    row_t r;
    r        = mk(f, b);
    r.typed  = typed;
    r.n      = n;
    r.res[0] = a0;
    r.res[1] = a1;
    r.res[2] = a2;
    table_rows.push_back(r);
  endtask

  task automatic send_word(input row_t r);
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= r.func;
    rx_byte_i  <= r.rx;
    word_row   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [7:0] data_pick();
    case ($urandom_range(0, 5))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_NUL;
      default: return 8'($urandom_range(0, 254));
    endcase
  endfunction

  task automatic random_phrase();
    int         sel;
    int         k;
    logic [7:0] opt;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      send_word(mk(FN_RX, data_pick()));
    end else if (sel < 40) begin
      send_word(mk(FN_RX, CH_CR));
      send_word(mk(FN_RX, data_pick()));
    end else if (sel < 70) begin
      case ($urandom_range(0, 4))
        0:       opt = OPT_BIN;
        1:       opt = OPT_ECHO;
        2:       opt = OPT_SGA;
        3:       opt = 8'($urandom_range(0, 7));
        default: opt = 8'($urandom_range(0, 255));
      endcase
      send_word(mk(FN_RX, TN_IAC));
      send_word(mk(FN_RX, TN_WILL + 8'($urandom_range(0, 3))));
      send_word(mk(FN_RX, opt));
    end else if (sel < 75) begin
      send_word(mk(FN_RX, TN_IAC));
      send_word(mk(FN_RX, TN_IAC));
    end else if (sel < 80) begin
      send_word(mk(FN_RX, TN_IAC));
      send_word(mk(FN_RX, TN_SB));
      for (k = $urandom_range(0, 3); k > 0; k--) begin
        send_word(mk(FN_RX, 8'($urandom_range(0, 254))));
      end
      if ($urandom_range(0, 1) == 1) begin
        send_word(mk(FN_RX, TN_IAC));
        send_word(mk(FN_RX, 8'($urandom_range(0, 239))));
      end
      send_word(mk(FN_RX, TN_IAC));
      send_word(mk(FN_RX, TN_SE));
    end else if (sel < 84) begin
      send_word(mk(FN_RX, TN_IAC));
      send_word(mk(FN_RX, 8'($urandom_range(240, 249))));
    end else if (sel < 90) begin
      send_word(mk(FN_GREET, 8'($urandom_range(0, 255))));
    end else begin
      send_word(mk(FN_RX, 8'($urandom_range(0, 255))));
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    int    mark;
    int    k;
    word_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        mark = reply_q.size();
        telnet_step(func_i, rx_byte_i);
        if (word_row.typed) begin
          while (reply_q.size() > mark) void'(reply_q.pop_back());
          for (k = 0; k < word_row.n; k++) begin
            w.chan  = word_row.res[k][8];
            w.dbyte = word_row.res[k][7:0];
            w.last  = (k == word_row.n - 1);
            reply_q.push_back(w);
          end
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (reply_q.size() == 0) begin
          note_error($sformatf("unexpected word chan %0d byte %02h", channel_o, data_byte_o));
        end else begin
          w = reply_q.pop_front();
          if (channel_o !== w.chan)
            note_error($sformatf("channel %0d, want %0d", channel_o, w.chan));
          if (data_byte_o !== w.dbyte)
            note_error($sformatf("data byte %02h, want %02h", data_byte_o, w.dbyte));
          if (last_of_run_o !== w.last)
            note_error($sformatf("last flag %0d, want %0d", last_of_run_o, w.last));
        end
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_out && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int i;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    func_i     = FN_RX;
    rx_byte_i  = 8'd0;
    word_row   = '0;
    parse_q    = PS_DATA;
    verb_q     = V_WILL;
    cr_q       = 1'b0;
    for (i = 0; i < 256; i++) begin
      local_opts[i]  = OS_OFF;
      remote_opts[i] = OS_OFF;
    end

    add_row(FN_RX, CH_NUL,  1'b1, 2'd1, {CHAN_USER, CH_NUL}, NO_WORD, NO_WORD);
    add_row(FN_RX, CH_CR,   1'b1, 2'd1, {CHAN_USER, CH_CR}, NO_WORD, NO_WORD);
    add_row(FN_RX, CH_LF,   1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, CH_CR,   1'b1, 2'd1, {CHAN_USER, CH_CR}, NO_WORD, NO_WORD);
    add_row(FN_RX, CH_NUL,  1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, CH_CR,   1'b1, 2'd1, {CHAN_USER, CH_CR}, NO_WORD, NO_WORD);
    // A command between CR and LF leaves the line ending folded.
    add_row(FN_RX, TN_IAC,  1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_NOP,  1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, CH_LF,   1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_IAC,  1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_IAC,  1'b1, 2'd1, {CHAN_USER, TN_IAC}, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_IAC,  1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_DO,   1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, OPT_ECHO, 1'b1, 2'd3,
            {CHAN_PEER, TN_IAC}, {CHAN_PEER, TN_WILL}, {CHAN_PEER, OPT_ECHO});
    add_row(FN_RX, TN_IAC,  1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_WILL, 1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, 8'hFF,   1'b1, 2'd3,
            {CHAN_PEER, TN_IAC}, {CHAN_PEER, TN_DONT}, {CHAN_PEER, 8'hFF});
    // A subnegotiation body is dropped, including an IAC that is not followed by SE.
    add_row(FN_RX, TN_IAC,  1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_SB,   1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_IAC,  1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, 8'h41,   1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_IAC,  1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_SE,   1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, 8'h80,   1'b1, 2'd1, {CHAN_USER, 8'h80}, NO_WORD, NO_WORD);
    add_row(FN_GREET, 8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_IAC,  1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, TN_DONT, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD);
    add_row(FN_RX, OPT_ECHO, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < table_rows.size(); i++) send_word(table_rows[i]);

    // Hold the input back until every queued word has drained.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);

    while (sent < 220) begin
      if (sent >= 185) begin
        idle_in  = 1'b0;
        idle_out = 1'b0;
      end else begin
        if ($urandom_range(0, 19) == 0) idle_in = !idle_in;
        if ($urandom_range(0, 19) == 0) idle_out = !idle_out;
      end
      random_phrase();
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
